// ===== design/afp_pkg.sv =====
`timescale 1ns / 1ps
package afp_pkg;

   localparam int SRC_COORD_BITS_DEF = 16;
   localparam int DST_FRAC_BITS_DEF  = 8;
   localparam int DST_INT_BITS       = 16;

   // Result word width, and binary points of the gains and offsets.
   localparam int OUT_W     = 48;
   localparam int LIN_POINT = 24;
   localparam int OFF_POINT = 16;

   // Divider: range check, one quotient bit per stage, output register.
   localparam int DIV_LAT = OUT_W + 2;

   localparam int LANES       = 6;
   localparam int OUTQ_DEPTH  = 2;

   typedef struct packed {
      logic [OUT_W-1:0] coef_xx;
      logic [OUT_W-1:0] coef_yx;
      logic [OUT_W-1:0] coef_xy;
      logic [OUT_W-1:0] coef_yy;
      logic [OUT_W-1:0] offset_x;
      logic [OUT_W-1:0] offset_y;
      logic             singular;
      logic             saturated;
   } rsp_item_type;

   // Width of the signed, already shifted numerator of any of the six quotients.
   function automatic int num_width(int s, int f);
      int a;
      int c;
      a = (DST_INT_BITS + f) + s + 3 + (LIN_POINT - f);
      c = (DST_INT_BITS + f) + 2 * s + 3 + (OFF_POINT - f);
      return (a > c) ? a : c;
   endfunction

endpackage

// ===== design/afp_if.sv =====
`timescale 1ns / 1ps
interface afp_req_if #(
   parameter int SRC_BITS = 16,
   parameter int DST_BITS = 24
);
   logic                       valid;
   logic                       ready;
   logic signed [SRC_BITS-1:0] src_x0;
   logic signed [SRC_BITS-1:0] src_y0;
   logic signed [SRC_BITS-1:0] src_x1;
   logic signed [SRC_BITS-1:0] src_y1;
   logic signed [SRC_BITS-1:0] src_x2;
   logic signed [SRC_BITS-1:0] src_y2;
   logic signed [DST_BITS-1:0] dst_x0;
   logic signed [DST_BITS-1:0] dst_y0;
   logic signed [DST_BITS-1:0] dst_x1;
   logic signed [DST_BITS-1:0] dst_y1;
   logic signed [DST_BITS-1:0] dst_x2;
   logic signed [DST_BITS-1:0] dst_y2;

   modport source (output valid, src_x0, src_y0, src_x1, src_y1, src_x2, src_y2,
                   dst_x0, dst_y0, dst_x1, dst_y1, dst_x2, dst_y2, input ready);
   modport sink (input valid, src_x0, src_y0, src_x1, src_y1, src_x2, src_y2,
                 dst_x0, dst_y0, dst_x1, dst_y1, dst_x2, dst_y2, output ready);
endinterface

interface afp_rsp_if;
   import afp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] coef_xx;
   logic signed [OUT_W-1:0] coef_yx;
   logic signed [OUT_W-1:0] coef_xy;
   logic signed [OUT_W-1:0] coef_yy;
   logic signed [OUT_W-1:0] offset_x;
   logic signed [OUT_W-1:0] offset_y;
   logic                    singular;
   logic                    saturated;

   modport source (output valid, coef_xx, coef_yx, coef_xy, coef_yy, offset_x, offset_y,
                   singular, saturated, input ready);
   modport sink (input valid, coef_xx, coef_yx, coef_xy, coef_yy, offset_x, offset_y,
                 singular, saturated, output ready);
endinterface

// ===== design/afp_front.sv =====
`timescale 1ns / 1ps
module afp_front #(
   parameter int SRC_COORD_BITS = afp_pkg::SRC_COORD_BITS_DEF,
   parameter int DST_FRAC_BITS  = afp_pkg::DST_FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic signed [SRC_COORD_BITS-1:0]              src_x [3],
   input  logic signed [SRC_COORD_BITS-1:0]              src_y [3],
   input  logic signed [afp_pkg::DST_INT_BITS+DST_FRAC_BITS-1:0] dst_u [2][3],
   output logic                                          out_valid,
   output logic                                          out_singular,
   output logic [afp_pkg::num_width(SRC_COORD_BITS, DST_FRAC_BITS):0] out_n [afp_pkg::LANES],
   output logic [2*SRC_COORD_BITS+3:0]                   out_d2,
   output logic                                          out_neg [afp_pkg::LANES]
);
   import afp_pkg::*;

   localparam int S     = SRC_COORD_BITS;
   localparam int D     = DST_INT_BITS + DST_FRAC_BITS;
   localparam int PA_W  = D + S + 2;
   localparam int MC_W  = D + 2 * S + 1;
   localparam int NA_W  = PA_W + 1;
   localparam int NC_W  = MC_W + 2;
   localparam int LIN   = LIN_POINT - DST_FRAC_BITS;
   localparam int OFF   = OFF_POINT - DST_FRAC_BITS;
   localparam int NW    = num_width(S, DST_FRAC_BITS);
   localparam int DW    = 2 * S + 3;

   // Stage A: coordinate differences.
   logic              a_valid_ff;
   logic signed [S-1:0] a_x_ff [3];
   logic signed [S-1:0] a_y_ff [3];
   logic signed [S:0]   a_dx1_ff, a_dy1_ff, a_dx2_ff, a_dy2_ff;
   logic signed [D-1:0] a_u_ff [2][3];
   logic signed [D:0]   a_du1_ff [2];
   logic signed [D:0]   a_du2_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff   <= src_x;
         a_y_ff   <= src_y;
         a_dx1_ff <= (S+1)'(src_x[1]) - (S+1)'(src_x[0]);
         a_dy1_ff <= (S+1)'(src_y[1]) - (S+1)'(src_y[0]);
         a_dx2_ff <= (S+1)'(src_x[2]) - (S+1)'(src_x[0]);
         a_dy2_ff <= (S+1)'(src_y[2]) - (S+1)'(src_y[0]);
         for (int ax = 0; ax < 2; ax++) begin
            a_u_ff[ax]   <= dst_u[ax];
            a_du1_ff[ax] <= (D+1)'(dst_u[ax][1]) - (D+1)'(dst_u[ax][0]);
            a_du2_ff[ax] <= (D+1)'(dst_u[ax][2]) - (D+1)'(dst_u[ax][0]);
         end
      end
   end

   // Stage B: products for the determinant and the cofactors.
   logic                  b_valid_ff;
   logic signed [2*S+1:0] b_pa_ff, b_pb_ff;
   logic signed [2*S-1:0] b_pc_ff [6];
   logic signed [S:0]     b_dx1_ff, b_dy1_ff, b_dx2_ff, b_dy2_ff;
   logic signed [D-1:0]   b_u_ff [2][3];
   logic signed [D:0]     b_du1_ff [2];
   logic signed [D:0]     b_du2_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pa_ff    <= (2*S+2)'(a_dx1_ff) * (2*S+2)'(a_dy2_ff);
         b_pb_ff    <= (2*S+2)'(a_dx2_ff) * (2*S+2)'(a_dy1_ff);
         b_pc_ff[0] <= (2*S)'(a_x_ff[1]) * (2*S)'(a_y_ff[2]);
         b_pc_ff[1] <= (2*S)'(a_x_ff[2]) * (2*S)'(a_y_ff[1]);
         b_pc_ff[2] <= (2*S)'(a_x_ff[2]) * (2*S)'(a_y_ff[0]);
         b_pc_ff[3] <= (2*S)'(a_x_ff[0]) * (2*S)'(a_y_ff[2]);
         b_pc_ff[4] <= (2*S)'(a_x_ff[0]) * (2*S)'(a_y_ff[1]);
         b_pc_ff[5] <= (2*S)'(a_x_ff[1]) * (2*S)'(a_y_ff[0]);
         b_dx1_ff   <= a_dx1_ff;
         b_dy1_ff   <= a_dy1_ff;
         b_dx2_ff   <= a_dx2_ff;
         b_dy2_ff   <= a_dy2_ff;
         b_u_ff     <= a_u_ff;
         b_du1_ff   <= a_du1_ff;
         b_du2_ff   <= a_du2_ff;
      end
   end

   // Stage C: determinant and cofactor sums.
   logic                  c_valid_ff;
   logic signed [DW-1:0]  c_det_ff;
   logic signed [2*S:0]   c_cof_ff [3];
   logic signed [S:0]     c_dx1_ff, c_dy1_ff, c_dx2_ff, c_dy2_ff;
   logic signed [D-1:0]   c_u_ff [2][3];
   logic signed [D:0]     c_du1_ff [2];
   logic signed [D:0]     c_du2_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_det_ff    <= DW'(b_pa_ff) - DW'(b_pb_ff);
         c_cof_ff[0] <= (2*S+1)'(b_pc_ff[0]) - (2*S+1)'(b_pc_ff[1]);
         c_cof_ff[1] <= (2*S+1)'(b_pc_ff[2]) - (2*S+1)'(b_pc_ff[3]);
         c_cof_ff[2] <= (2*S+1)'(b_pc_ff[4]) - (2*S+1)'(b_pc_ff[5]);
         c_dx1_ff    <= b_dx1_ff;
         c_dy1_ff    <= b_dy1_ff;
         c_dx2_ff    <= b_dx2_ff;
         c_dy2_ff    <= b_dy2_ff;
         c_u_ff      <= b_u_ff;
         c_du1_ff    <= b_du1_ff;
         c_du2_ff    <= b_du2_ff;
      end
   end

   // Stage D: numerator products for both axes.
   logic                   d_valid_ff;
   logic                   d_sing_ff;
   logic signed [DW-1:0]   d_det_ff;
   logic signed [PA_W-1:0] d_ma1_ff [2];
   logic signed [PA_W-1:0] d_ma2_ff [2];
   logic signed [PA_W-1:0] d_mb1_ff [2];
   logic signed [PA_W-1:0] d_mb2_ff [2];
   logic signed [MC_W-1:0] d_mc_ff [2][3];
   logic signed [D-1:0]    d_u_ff [2][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_sing_ff <= (c_det_ff == '0);
         d_det_ff  <= c_det_ff;
         d_u_ff    <= c_u_ff;
         for (int ax = 0; ax < 2; ax++) begin
            d_ma1_ff[ax] <= PA_W'(c_du1_ff[ax]) * PA_W'(c_dy2_ff);
            d_ma2_ff[ax] <= PA_W'(c_du2_ff[ax]) * PA_W'(c_dy1_ff);
            d_mb1_ff[ax] <= PA_W'(c_dx1_ff) * PA_W'(c_du2_ff[ax]);
            d_mb2_ff[ax] <= PA_W'(c_dx2_ff) * PA_W'(c_du1_ff[ax]);
            for (int k = 0; k < 3; k++) begin
               d_mc_ff[ax][k] <= MC_W'(c_u_ff[ax][k]) * MC_W'(c_cof_ff[k]);
            end
         end
      end
   end

   // Stage E: numerator sums, scaled to the output binary point. A collinear
   // set falls back to the identity inverse with a unit denominator.
   logic                  e_valid_ff;
   logic                  e_sing_ff;
   logic signed [NW-1:0]  e_num_ff [LANES];
   logic signed [DW-1:0]  e_den_ff;
   logic signed [NW-1:0]  e_num_in [LANES];
   logic signed [NA_W-1:0] e_na [2];
   logic signed [NA_W-1:0] e_nb [2];
   logic signed [NC_W-1:0] e_nc [2];

   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         e_na[ax] = NA_W'(d_ma1_ff[ax]) - NA_W'(d_ma2_ff[ax]);
         e_nb[ax] = NA_W'(d_mb1_ff[ax]) - NA_W'(d_mb2_ff[ax]);
         e_nc[ax] = NC_W'(d_mc_ff[ax][0]) + NC_W'(d_mc_ff[ax][1]) + NC_W'(d_mc_ff[ax][2]);
         if (d_sing_ff) begin
            e_num_in[ax]     = NW'(d_u_ff[ax][1]) <<< LIN;
            e_num_in[2 + ax] = NW'(d_u_ff[ax][2]) <<< LIN;
            e_num_in[4 + ax] = NW'(d_u_ff[ax][0]) <<< OFF;
         end else begin
            e_num_in[ax]     = NW'(e_na[ax]) <<< LIN;
            e_num_in[2 + ax] = NW'(e_nb[ax]) <<< LIN;
            e_num_in[4 + ax] = NW'(e_nc[ax]) <<< OFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_sing_ff <= d_sing_ff;
         e_num_ff  <= e_num_in;
         e_den_ff  <= d_sing_ff ? DW'(1) : d_det_ff;
      end
   end

   // Stage F: magnitudes and quotient signs.
   logic              f_valid_ff;
   logic              f_sing_ff;
   logic [NW-1:0]     f_mag_ff [LANES];
   logic              f_neg_ff [LANES];
   logic [DW-1:0]     f_absd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_sing_ff <= e_sing_ff;
         f_absd_ff <= e_den_ff[DW-1] ? DW'(-e_den_ff) : DW'(e_den_ff);
         for (int l = 0; l < LANES; l++) begin
            f_mag_ff[l] <= e_num_ff[l][NW-1] ? NW'(-e_num_ff[l]) : NW'(e_num_ff[l]);
            f_neg_ff[l] <= e_num_ff[l][NW-1] ^ e_den_ff[DW-1];
         end
      end
   end

   // Stage G: 2|num| + |den| over 2|den| rounds the quotient half away from zero.
   logic              g_valid_ff;
   logic              g_sing_ff;
   logic [NW:0]       g_n_ff [LANES];
   logic              g_neg_ff [LANES];
   logic [DW:0]       g_d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_sing_ff <= f_sing_ff;
         g_d2_ff   <= {f_absd_ff, 1'b0};
         g_neg_ff  <= f_neg_ff;
         for (int l = 0; l < LANES; l++) begin
            g_n_ff[l] <= {f_mag_ff[l], 1'b0} + (NW+1)'(f_absd_ff);
         end
      end
   end

   assign out_valid    = g_valid_ff;
   assign out_singular = g_sing_ff;
   assign out_n        = g_n_ff;
   assign out_d2       = g_d2_ff;
   assign out_neg      = g_neg_ff;

endmodule

// ===== design/afp_div.sv =====
`timescale 1ns / 1ps
module afp_div #(
   parameter int N_W  = 68,
   parameter int D2_W = 36
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [N_W-1:0]             n,
   input  logic [D2_W-1:0]            d2,
   input  logic                       neg,
   output logic [afp_pkg::OUT_W-1:0]  value,
   output logic                       sat
);
   import afp_pkg::*;

   localparam int QW = OUT_W;
   localparam int W  = D2_W + QW;

   logic [W-1:0]    r_ff  [QW+1];
   logic [QW-1:0]   q_ff  [QW+1];
   logic [D2_W-1:0] dd_ff [QW+1];
   logic            neg_ff [QW+1];
   logic            sat_ff [QW+1];

   // A quotient of 2^48 or more saturates in any case; past this check the
   // remainder always fits below d2 shifted by the quotient width.
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= W'(n);
         q_ff[0]   <= '0;
         dd_ff[0]  <= d2;
         neg_ff[0] <= neg;
         sat_ff[0] <= (W'(n) >= (W'(d2) << QW));
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      localparam int BIT = QW - k;
      logic [W-1:0] trial;
      assign trial = W'(dd_ff[k-1]) << BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (r_ff[k-1] >= trial) begin
               r_ff[k] <= r_ff[k-1] - trial;
               q_ff[k] <= q_ff[k-1] | (QW'(1) << BIT);
            end else begin
               r_ff[k] <= r_ff[k-1];
               q_ff[k] <= q_ff[k-1];
            end
            dd_ff[k]  <= dd_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   logic [QW-1:0] limit;
   logic [QW-1:0] mag;
   logic          over;
   logic [QW-1:0] value_ff;
   logic          sat_out_ff;

   always_comb begin
      limit = neg_ff[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
      over  = sat_ff[QW] || (q_ff[QW] > limit);
      mag   = over ? limit : q_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff   <= neg_ff[QW] ? (QW'(0) - mag) : mag;
         sat_out_ff <= over;
      end
   end

   assign value = value_ff;
   assign sat   = sat_out_ff;

endmodule

// ===== design/afp_outq.sv =====
`timescale 1ns / 1ps
module afp_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  afp_pkg::rsp_item_type push_item,
   output logic                  full,
   afp_rsp_if.source             rsp
);
   import afp_pkg::*;

   localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

   rsp_item_type     slot_ff [OUTQ_DEPTH];
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   rsp_item_type     head;

   assign pop  = rsp.valid && rsp.ready;
   assign full = (count_ff == CNT_W'(OUTQ_DEPTH));
   assign head = slot_ff[rd_ff];

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      count_in = count_ff;
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push) begin
         wr_in = (wr_ff == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.coef_xx   = head.coef_xx;
   assign rsp.coef_yx   = head.coef_yx;
   assign rsp.coef_xy   = head.coef_xy;
   assign rsp.coef_yy   = head.coef_yy;
   assign rsp.offset_x  = head.offset_x;
   assign rsp.offset_y  = head.offset_y;
   assign rsp.singular  = head.singular;
   assign rsp.saturated = head.saturated;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(OUTQ_DEPTH)))
      else $error("item pushed into a full output queue");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("output queue lost an item while stalled");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("output queue count did not follow a push");

   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.singular) |-> !rsp.saturated)
      else $error("identity fallback reported as saturated");
`endif

endmodule

// ===== design/affine_from_three_point_pairs.sv =====
`timescale 1ns / 1ps
// Affine map from three point correspondences.
// The req channel carries one item: three source points (signed integers) and
// three target points (signed Q16.8). For each item the rsp channel returns one
// item with the four gains (Q24.24), the two offsets (Q32.16), a singular flag
// for collinear source points (identity inverse used) and a saturated flag.
// Both channels use valid/ready; an item moves when both are high.
// Throughput is one item per cycle while the output queue is not full. An
// accepted item passes seven stages of differences, products and sums, then
// one 50-stage divider per result that retires one quotient bit a stage, then
// the output queue before it reaches rsp.valid.
// The output queue holds two items. While the receiver stalls, the pipeline
// keeps moving until the queue is full; then the whole pipeline holds and
// req.ready drops, so nothing is lost or repeated. req.ready does not depend
// combinationally on rsp.ready.
// Reset clears all valid bits and the queue; the data registers are not reset,
// and the block accepts items in the first cycle after reset.
module affine_from_three_point_pairs #(
   parameter int SRC_COORD_BITS = afp_pkg::SRC_COORD_BITS_DEF,
   parameter int DST_FRAC_BITS  = afp_pkg::DST_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   afp_req_if.sink   req,
   afp_rsp_if.source rsp
);
   import afp_pkg::*;

   localparam int S    = SRC_COORD_BITS;
   localparam int D    = DST_INT_BITS + DST_FRAC_BITS;
   localparam int NW   = num_width(S, DST_FRAC_BITS);
   localparam int D2_W = 2 * S + 4;

   logic                en;
   logic                full;
   logic signed [S-1:0] src_x [3];
   logic signed [S-1:0] src_y [3];
   logic signed [D-1:0] dst_u [2][3];
   logic                f_valid;
   logic                f_singular;
   logic [NW:0]         f_n [LANES];
   logic [D2_W-1:0]     f_d2;
   logic                f_neg [LANES];
   logic [OUT_W-1:0]    lane_value [LANES];
   logic                lane_sat [LANES];
   logic [DIV_LAT-1:0]  vpipe_ff;
   logic [DIV_LAT-1:0]  spipe_ff;
   logic                push;
   rsp_item_type        push_item;

   assign en        = !full;
   assign req.ready = en;

   assign src_x[0]    = req.src_x0;
   assign src_y[0]    = req.src_y0;
   assign src_x[1]    = req.src_x1;
   assign src_y[1]    = req.src_y1;
   assign src_x[2]    = req.src_x2;
   assign src_y[2]    = req.src_y2;
   assign dst_u[0][0] = req.dst_x0;
   assign dst_u[1][0] = req.dst_y0;
   assign dst_u[0][1] = req.dst_x1;
   assign dst_u[1][1] = req.dst_y1;
   assign dst_u[0][2] = req.dst_x2;
   assign dst_u[1][2] = req.dst_y2;

   afp_front #(
      .SRC_COORD_BITS (SRC_COORD_BITS),
      .DST_FRAC_BITS  (DST_FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req.valid),
      .src_x        (src_x),
      .src_y        (src_y),
      .dst_u        (dst_u),
      .out_valid    (f_valid),
      .out_singular (f_singular),
      .out_n        (f_n),
      .out_d2       (f_d2),
      .out_neg      (f_neg)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      afp_div #(
         .N_W  (NW + 1),
         .D2_W (D2_W)
      ) u_div (
         .clock (clock),
         .en    (en),
         .n     (f_n[l]),
         .d2    (f_d2),
         .neg   (f_neg[l]),
         .value (lane_value[l]),
         .sat   (lane_sat[l])
      );
   end

   // Valid and singular bits ride alongside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff <= '0;
      end else if (en) begin
         vpipe_ff <= {vpipe_ff[DIV_LAT-2:0], f_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spipe_ff <= {spipe_ff[DIV_LAT-2:0], f_singular};
      end
   end

   assign push = en && vpipe_ff[DIV_LAT-1];

   always_comb begin
      push_item.coef_xx   = lane_value[0];
      push_item.coef_yx   = lane_value[1];
      push_item.coef_xy   = lane_value[2];
      push_item.coef_yy   = lane_value[3];
      push_item.offset_x  = lane_value[4];
      push_item.offset_y  = lane_value[5];
      push_item.singular  = spipe_ff[DIV_LAT-1];
      push_item.saturated = lane_sat[0] | lane_sat[1] | lane_sat[2] |
                            lane_sat[3] | lane_sat[4] | lane_sat[5];
   end

   afp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .rsp       (rsp)
   );

endmodule

// ===== dv/tb_affine_from_three_point_pairs.sv =====
`timescale 1ns / 1ps
module tb_affine_from_three_point_pairs;
   import afp_pkg::*;

   localparam int SB = SRC_COORD_BITS_DEF;
   localparam int DB = DST_INT_BITS + DST_FRAC_BITS_DEF;
   localparam int LIN_SH = LIN_POINT - DST_FRAC_BITS_DEF;
   localparam int OFF_SH = OFF_POINT - DST_FRAC_BITS_DEF;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1750;

   typedef struct {
      logic signed [SB-1:0] px[3];
      logic signed [SB-1:0] py[3];
      logic signed [DB-1:0] tx[3];
      logic signed [DB-1:0] ty[3];
   } point_set_type;

   class affine_book;
      rsp_item_type maps[$];
      bit clamp_seen;
      int n_singular;
      int n_saturated;

      // Rounded division, ties away from zero, clamped to the 48-bit range.
      function logic [OUT_W-1:0] divide_round(logic signed [127:0] num,
                                              logic signed [127:0] den);
         logic [127:0] n;
         logic [127:0] d;
         logic [127:0] q;
         logic [127:0] lim;
         bit neg;
         n = num < 0 ? -num : num;
         d = den < 0 ? -den : den;
         neg = (num < 0) != (den < 0);
         q = (2 * n + d) / (2 * d);
         lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
         if (q > lim) begin
            q = lim;
            clamp_seen = 1;
         end
         if (neg) q = -q;
         return q[OUT_W-1:0];
      endfunction

      function void note(point_set_type s);
         logic signed [127:0] x[3], y[3], u[3];
         logic signed [127:0] dx1, dy1, dx2, dy2, det, c0, c1, c2;
         logic signed [127:0] na, nb, nc, den;
         logic [OUT_W-1:0] lin_a[2], lin_b[2], off[2];
         rsp_item_type m;
         for (int i = 0; i < 3; i++) begin
            x[i] = 128'(s.px[i]);
            y[i] = 128'(s.py[i]);
         end
         dx1 = x[1] - x[0];
         dy1 = y[1] - y[0];
         dx2 = x[2] - x[0];
         dy2 = y[2] - y[0];
         det = dx1 * dy2 - dx2 * dy1;
         c0 = x[1] * y[2] - x[2] * y[1];
         c1 = x[2] * y[0] - x[0] * y[2];
         c2 = x[0] * y[1] - x[1] * y[0];
         clamp_seen = 0;
         for (int ax = 0; ax < 2; ax++) begin
            for (int i = 0; i < 3; i++) u[i] = (ax == 0) ? 128'(s.tx[i]) : 128'(s.ty[i]);
            if (det == 0) begin
               // Collinear sources: identity inverse, targets pass straight through.
               na = u[1];
               nb = u[2];
               nc = u[0];
               den = 128'(1);
            end else begin
               na = (u[1] - u[0]) * dy2 - (u[2] - u[0]) * dy1;
               nb = dx1 * (u[2] - u[0]) - dx2 * (u[1] - u[0]);
               nc = u[0] * c0 + u[1] * c1 + u[2] * c2;
               den = det;
            end
            lin_a[ax] = divide_round(na <<< LIN_SH, den);
            lin_b[ax] = divide_round(nb <<< LIN_SH, den);
            off[ax] = divide_round(nc <<< OFF_SH, den);
         end
         m.coef_xx = lin_a[0];
         m.coef_yx = lin_a[1];
         m.coef_xy = lin_b[0];
         m.coef_yy = lin_b[1];
         m.offset_x = off[0];
         m.offset_y = off[1];
         m.singular = (det == 0);
         m.saturated = clamp_seen;
         n_singular += m.singular;
         n_saturated += m.saturated;
         maps.push_back(m);
      endfunction

      // Returns one line per wrong field; an unexpected result gives one line too.
      function void check(rsp_item_type got, ref string faults[$]);
         rsp_item_type e;
         faults.delete();
         if (maps.size() == 0) begin
            faults.push_back("result item arrived with no prediction pending");
            return;
         end
         e = maps.pop_front();
         if (got.coef_xx !== e.coef_xx)
            faults.push_back($sformatf("coef_xx got %h exp %h", got.coef_xx, e.coef_xx));
         if (got.coef_yx !== e.coef_yx)
            faults.push_back($sformatf("coef_yx got %h exp %h", got.coef_yx, e.coef_yx));
         if (got.coef_xy !== e.coef_xy)
            faults.push_back($sformatf("coef_xy got %h exp %h", got.coef_xy, e.coef_xy));
         if (got.coef_yy !== e.coef_yy)
            faults.push_back($sformatf("coef_yy got %h exp %h", got.coef_yy, e.coef_yy));
         if (got.offset_x !== e.offset_x)
            faults.push_back($sformatf("offset_x got %h exp %h", got.offset_x, e.offset_x));
         if (got.offset_y !== e.offset_y)
            faults.push_back($sformatf("offset_y got %h exp %h", got.offset_y, e.offset_y));
         if (got.singular !== e.singular)
            faults.push_back($sformatf("singular got %b exp %b", got.singular, e.singular));
         if (got.saturated !== e.saturated)
            faults.push_back($sformatf("saturated got %b exp %b", got.saturated,
                                       e.saturated));
      endfunction
   endclass

   logic clock;
   logic reset;
   int errors;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;
   int n_sent;
   int n_checked;
   affine_book book;

   afp_req_if #(.SRC_BITS(SB), .DST_BITS(DB)) rq();
   afp_rsp_if rs();

   affine_from_three_point_pairs DUT (
      .clock(clock),
      .reset(reset),
      .req(rq),
      .rsp(rs)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic send(point_set_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         rq.valid <= 1'b0;
         @(negedge clock);
      end
      rq.valid <= 1'b1;
      {rq.src_x0, rq.src_x1, rq.src_x2} <= {s.px[0], s.px[1], s.px[2]};
      {rq.src_y0, rq.src_y1, rq.src_y2} <= {s.py[0], s.py[1], s.py[2]};
      {rq.dst_x0, rq.dst_x1, rq.dst_x2} <= {s.tx[0], s.tx[1], s.tx[2]};
      {rq.dst_y0, rq.dst_y1, rq.dst_y2} <= {s.ty[0], s.ty[1], s.ty[2]};
      do @(posedge clock); while (!rq.ready);
      book.note(s);
      n_sent++;
      @(negedge clock);
   endtask

   function automatic point_set_type pts(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int u0, int v0, int u1, int v1, int u2, int v2);
      point_set_type s;
      s.px = '{SB'(x0), SB'(x1), SB'(x2)};
      s.py = '{SB'(y0), SB'(y1), SB'(y2)};
      s.tx = '{DB'(u0), DB'(u1), DB'(u2)};
      s.ty = '{DB'(v0), DB'(v1), DB'(v2)};
      return s;
   endfunction

   function automatic point_set_type random_set();
      point_set_type s;
      int kind;
      int k1;
      int k2;
      int bx;
      int by;
      int ex;
      int ey;
      kind = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         s.px[i] = SB'($urandom);
         s.py[i] = SB'($urandom);
         s.tx[i] = DB'($urandom);
         s.ty[i] = DB'($urandom);
      end
      if (kind < 20) begin
         // Tiny triangles give large gains and often clamp.
         for (int i = 0; i < 3; i++) begin
            s.px[i] = SB'($signed($urandom_range(8)) - 4);
            s.py[i] = SB'($signed($urandom_range(8)) - 4);
         end
      end else if (kind < 35) begin
         // Collinear sources take the identity-inverse path.
         bx = $signed($urandom_range(2000)) - 1000;
         by = $signed($urandom_range(2000)) - 1000;
         ex = $signed($urandom_range(200)) - 100;
         ey = $signed($urandom_range(200)) - 100;
         k1 = $signed($urandom_range(20)) - 10;
         k2 = $signed($urandom_range(20)) - 10;
         s.px = '{SB'(bx), SB'(bx + k1 * ex), SB'(bx + k2 * ex)};
         s.py = '{SB'(by), SB'(by + k1 * ey), SB'(by + k2 * ey)};
      end else if (kind < 60) begin
         // A plausible image triangle mapped to nearby targets.
         for (int i = 0; i < 3; i++) begin
            s.px[i] = SB'($urandom_range(1023));
            s.py[i] = SB'($urandom_range(1023));
            s.tx[i] = DB'($signed($urandom_range(1 << 19)) - (1 << 18));
            s.ty[i] = DB'($signed($urandom_range(1 << 19)) - (1 << 18));
         end
      end
      return s;
   endfunction

   always @(negedge clock) begin
      if (reset) rs.ready <= 1'b0;
      else rs.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type got;
      string faults[$];
      if (!reset) begin
         if ((rq.valid && rq.ready) || (rs.valid && rs.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rs.valid && rs.ready) begin
            got = '{rs.coef_xx, rs.coef_yx, rs.coef_xy, rs.coef_yy, rs.offset_x,
                    rs.offset_y, rs.singular, rs.saturated};
            book.check(got, faults);
            foreach (faults[i]) report(faults[i]);
            n_checked++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      point_set_type directed[$];
      book = new();
      errors = 0;
      idle_cycles = 0;
      n_sent = 0;
      n_checked = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      rq.valid = 1'b0;
      {rq.src_x0, rq.src_y0, rq.src_x1, rq.src_y1, rq.src_x2, rq.src_y2} = '0;
      {rq.dst_x0, rq.dst_y0, rq.dst_x1, rq.dst_y1, rq.dst_x2, rq.dst_y2} = '0;
      rs.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back(pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(pts(0, 0, 0, 0, 0, 0, 8388607, -8388608, 8388607, -8388608,
                             -8388608, 8388607));
      directed.push_back(pts(0, 0, 1, 0, 0, 1, 0, 0, 256, 0, 0, 256));
      directed.push_back(pts(0, 0, 1, 0, 0, 1, 8388607, -8388608, -8388608, 8388607,
                             8388607, -8388608));
      directed.push_back(pts(0, 0, 0, 1, 1, 0, 100, 200, 300, 400, 500, 600));
      directed.push_back(pts(32767, 32767, -32768, 32767, 32767, -32768, 8388607,
                             8388607, -8388608, -8388608, 0, 0));
      directed.push_back(pts(-32768, -32768, 32767, -32768, -32768, 32767, -8388608,
                             8388607, 8388607, -8388608, 8388607, 8388607));
      directed.push_back(pts(-32768, -32768, 32767, 32767, 0, 0, 1, 2, 3, 4, 5, 6));
      directed.push_back(pts(-32768, -32768, 32767, 32767, 32767, 32766, 8388607,
                             -8388608, -8388608, 8388607, 8388607, -8388608));
      directed.push_back(pts(1, 1, 2, 2, 3, 3, -1, -1, -1, -1, -1, -1));
      directed.push_back(pts(10, 10, 20, 10, 10, 20, -2560, 2560, 2560, -2560, 0, 0));
      directed.push_back(pts(0, 0, 3, 0, 0, 3, 1, 1, 2, 2, 0, 0));
      directed.push_back(pts(0, 0, 2, 0, 0, 2, 1, -1, 2, -2, 3, -3));
      directed.push_back(pts(-1, -1, 1, 0, 0, 1, 128, -128, -128, 128, 384, -384));
      directed.push_back(pts(100, -200, -300, 400, 500, 600, 1000, -2000, 3000, -4000,
                             5000, -6000));
      directed.push_back(pts(32767, 0, 0, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0));
      directed.push_back(pts(5, 5, 5, 5, 7, 9, 8388607, 8388607, 8388607, 8388607,
                             8388607, 8388607));
      directed.push_back(pts(0, 0, 1, 1, 1, 2, -8388608, -8388608, 8388607, 8388607,
                             -8388608, -8388608));
      foreach (directed[i]) send(directed[i]);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            3: begin send_idle_pct = 20; stall_pct = 20; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         for (int i = 0; i < RANDOM_ITEMS / 5; i++) send(random_set());
      end
      rq.valid <= 1'b0;
      stall_pct = 0;

      while (book.maps.size() > 0) @(posedge clock);
      repeat (DIV_LAT + 20) @(posedge clock);

      $display("Sent %0d point sets and checked %0d maps under five idle/stall mixes.",
               n_sent, n_checked);
      $display("Predicted %0d collinear sets and %0d clamped maps; %0d mismatches.",
               book.n_singular, book.n_saturated, errors);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== affine_from_three_point_pairs.f =====
design/afp_pkg.sv
design/afp_if.sv
design/afp_front.sv
design/afp_div.sv
design/afp_outq.sv
design/affine_from_three_point_pairs.sv
dv/tb_affine_from_three_point_pairs.sv
